/* design/pcsc_pkg.sv */
// Package for the PNG chunk structure checker.
// Holds result types, chunk type codes and the signature table; no dependencies.
package pcsc_pkg;

  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  typedef enum logic [2:0] {
    CAUSE_NONE    = 3'd0,
    CAUSE_BAD_SIG = 3'd1,
    CAUSE_NO_IHDR = 3'd2,
    CAUSE_NO_IDAT = 3'd3,
    CAUSE_NO_IEND = 3'd4
  } cause_t;

  localparam logic KIND_IDAT    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic        report_kind;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_crc;
    logic        file_valid;
    logic [2:0]  failure_cause;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'h0A;
      3'd6:    b = 8'h1A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

endpackage

/* design/pcsc_parser.sv */
// Chunk walker: consumes one registered byte beat per cycle and emits up to
// two results (IDAT report, verdict). Depends on pcsc_pkg.
module pcsc_parser import pcsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       beat_valid,
  input  logic [7:0] beat_byte,
  input  logic       beat_eof,
  output push_t      push
);

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] fc_r, fc_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        ihdr_r, ihdr_nxt;
  logic        idat_r, idat_nxt;
  logic        verd_r, verd_nxt;

  logic        rep;
  logic        verd;
  logic        verd_ok;
  logic [2:0]  verd_cause;
  logic [31:0] type_new;
  logic [31:0] crc_new;
  logic [31:0] fc_inc;
  result_t     rep_res;
  result_t     verd_res;

  always_comb begin
    phase_nxt  = phase_r;
    fc_nxt     = fc_r;
    off_nxt    = off_r + 32'd1;
    start_nxt  = start_r;
    len_nxt    = len_r;
    type_nxt   = type_r;
    crc_nxt    = crc_r;
    ihdr_nxt   = ihdr_r;
    idat_nxt   = idat_r;
    verd_nxt   = verd_r;
    rep        = 1'b0;
    verd       = 1'b0;
    verd_ok    = 1'b0;
    verd_cause = CAUSE_NONE;
    type_new   = {type_r[23:0], beat_byte};
    crc_new    = {crc_r[23:0], beat_byte};
    fc_inc     = fc_r + 32'd1;

    unique case (phase_r)
      PH_SIG: begin
        if (beat_byte != sig_byte(fc_r[2:0])) begin
          verd       = 1'b1;
          verd_cause = CAUSE_BAD_SIG;
        end else if (fc_r >= 32'd7) begin
          phase_nxt = PH_LEN;
          fc_nxt    = '0;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      PH_LEN: begin
        if (fc_r == '0) start_nxt = off_r;
        len_nxt = {len_r[23:0], beat_byte};
        if (fc_r >= 32'd3) begin
          phase_nxt = PH_TYPE;
          fc_nxt    = '0;
        end else begin
          fc_nxt = fc_inc;
        end
      end
      PH_TYPE: begin
        type_nxt = type_new;
        if (fc_r < 32'd3) begin
          fc_nxt = fc_inc;
        end else begin
          fc_nxt    = '0;
          phase_nxt = (len_r == '0) ? PH_CRC : PH_DATA;
          if (!ihdr_r) begin
            if (type_new != TYPE_IHDR) begin
              verd       = 1'b1;
              verd_cause = CAUSE_NO_IHDR;
            end else begin
              ihdr_nxt = 1'b1;
            end
          end else if (type_new == TYPE_IEND) begin
            verd       = 1'b1;
            verd_ok    = idat_r;
            verd_cause = idat_r ? CAUSE_NONE : CAUSE_NO_IDAT;
          end else if (type_new == TYPE_IDAT) begin
            idat_nxt = 1'b1;
          end
        end
      end
      PH_DATA: begin
        fc_nxt = fc_inc;
        if (fc_inc >= len_r) begin
          phase_nxt = PH_CRC;
          fc_nxt    = '0;
        end
      end
      PH_CRC: begin
        crc_nxt = crc_new;
        if (fc_r < 32'd3) begin
          fc_nxt = fc_inc;
        end else begin
          rep       = (type_r == TYPE_IDAT);
          phase_nxt = PH_LEN;
          fc_nxt    = '0;
          len_nxt   = '0;
          type_nxt  = '0;
          crc_nxt   = '0;
        end
      end
      default: begin
      end
    endcase

    if (verd) begin
      verd_nxt  = 1'b1;
      phase_nxt = PH_DONE;
    end

    if (beat_eof) begin
      if (!verd_nxt) begin
        verd    = 1'b1;
        verd_ok = 1'b0;
        if (phase_r == PH_SIG)  verd_cause = CAUSE_BAD_SIG;
        else if (!ihdr_nxt)     verd_cause = CAUSE_NO_IHDR;
        else if (!idat_nxt)     verd_cause = CAUSE_NO_IDAT;
        else                    verd_cause = CAUSE_NO_IEND;
      end
      phase_nxt = PH_SIG;
      fc_nxt    = '0;
      off_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
      type_nxt  = '0;
      crc_nxt   = '0;
      ihdr_nxt  = 1'b0;
      idat_nxt  = 1'b0;
      verd_nxt  = 1'b0;
    end
  end

  always_comb begin
    rep_res               = '0;
    rep_res.report_kind   = KIND_IDAT;
    rep_res.chunk_offset  = start_r;
    rep_res.chunk_crc     = crc_new;
    rep_res.last_of_run   = !verd;
    verd_res              = '0;
    verd_res.report_kind  = KIND_VERDICT;
    verd_res.file_valid   = verd_ok;
    verd_res.failure_cause = verd_cause;
    verd_res.last_of_run  = 1'b1;
    push.num = beat_valid ? ({1'b0, rep} + {1'b0, verd}) : 2'd0;
    push.r0  = rep ? rep_res : verd_res;
    push.r1  = verd_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      fc_r    <= '0;
      off_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      type_r  <= '0;
      crc_r   <= '0;
      ihdr_r  <= 1'b0;
      idat_r  <= 1'b0;
      verd_r  <= 1'b0;
    end else if (beat_valid) begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      off_r   <= off_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      crc_r   <= crc_nxt;
      ihdr_r  <= ihdr_nxt;
      idat_r  <= idat_nxt;
      verd_r  <= verd_nxt;
    end
  end

`ifndef SYNTH
  a_done_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> verd_r)
    else $error("done phase without verdict flag");
  a_verd_moves_done: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_valid && verd && !beat_eof) |=> (phase_r == PH_DONE))
    else $error("verdict did not enter done phase");
  a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_valid && beat_eof) |=> (phase_r == PH_SIG && off_r == '0 && !verd_r))
    else $error("end of file did not restart parser");
`endif

endmodule

/* design/pcsc_result_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per beat.
// Depends on pcsc_pkg.
module pcsc_result_fifo import pcsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  push_t              push,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            out_res,
  output logic [ResCntW-1:0] count
);

  result_t            mem [ResDepth];
  logic [ResPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ResPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ResCntW-1:0] cnt_r, cnt_nxt;
  logic               pop;
  logic [ResPtrW-1:0] wr_ptr_p1;

  assign pop        = out_valid && out_ready;
  assign wr_ptr_p1  = wr_ptr_r + ResPtrW'(1);
  assign wr_ptr_nxt = wr_ptr_r + ResPtrW'(push.num);
  assign rd_ptr_nxt = rd_ptr_r + ResPtrW'(pop);
  assign cnt_nxt    = cnt_r + ResCntW'(push.num) - ResCntW'(pop);
  assign out_valid  = (cnt_r != '0);
  assign out_res    = mem[rd_ptr_r];
  assign count      = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) mem[wr_ptr_r]  <= push.r0;
    if (push.num == 2'd2) mem[wr_ptr_p1] <= push.r1;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cnt_r) + 32'(push.num)) <= 32'(ResDepth))
    else $error("result queue overflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num == 2'd0 && !pop) |=> $stable(cnt_r))
    else $error("result count changed while idle");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !pop)
    else $error("pop from empty result queue");
`endif

endmodule

/* design/png_chunk_structure_checker.sv */
// PNG chunk structure checker, top level. A byte beat is registered, then its
// results queued for out_*; a second result (verdict after IDAT report) follows.
// Throughput: 1 byte per cycle while the result queue has room for two results
// beyond those in flight; the 4-entry result queue sets that figure.
// Reset: synchronous active-low rst_n clears parser state and empties the queue.
module png_chunk_structure_checker import pcsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_report_kind,
  output logic [31:0] out_chunk_offset,
  output logic [31:0] out_chunk_crc,
  output logic        out_file_valid,
  output logic [2:0]  out_failure_cause,
  output logic        out_last_of_run
);

  logic               vld_r;
  logic [7:0]         byte_r;
  logic               eof_r;
  logic [ResCntW-1:0] cnt;
  push_t              push;
  result_t            res;

  assign in_ready = (32'(cnt) + (vld_r ? 32'd2 : 32'd0) + 32'd2) <= 32'(ResDepth);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      eof_r  <= in_end_of_file;
    end
  end

  pcsc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (vld_r),
    .beat_byte  (byte_r),
    .beat_eof   (eof_r),
    .push       (push)
  );

  pcsc_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .count     (cnt)
  );

  assign out_report_kind   = res.report_kind;
  assign out_chunk_offset  = res.chunk_offset;
  assign out_chunk_crc     = res.chunk_crc;
  assign out_file_valid    = res.file_valid;
  assign out_failure_cause = res.failure_cause;
  assign out_last_of_run   = res.last_of_run;

`ifndef SYNTH
  a_room_for_beat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (32'(cnt) <= 32'(ResDepth) - 32'd2))
    else $error("byte beat without queue room");
  a_accept_registers: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r)
    else $error("accepted byte not registered");
  a_no_ghost_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) |=> !vld_r)
    else $error("byte beat without accept");
`endif

endmodule
